### design/scpb_pkg.sv
// Shared types and constants for the strip coincidence pixel builder.
package scpb_pkg;

	localparam int TIME_W      = 50;
	localparam int STRIP_W     = 8;
	localparam int ENERGY_W    = 16;
	localparam int WIN_W       = 20;
	localparam int PIX_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 96;

	localparam logic [WIN_W-1:0] WIN_RESET = 20'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIN_FF = 3'd0,
		CFG_WIN_FB = 3'd1,
		CFG_WIN_BF = 3'd2,
		CFG_WIN_BB = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [WIN_W-1:0] front_front;
		logic [WIN_W-1:0] front_back;
		logic [WIN_W-1:0] back_front;
		logic [WIN_W-1:0] back_back;
	} win_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]    pixel_x;
		logic [PIX_W-1:0]    pixel_y;
		logic [TIME_W-1:0]   pixel_time;
		logic [ENERGY_W-1:0] energy_front;
		logic [ENERGY_W-1:0] energy_back;
	} pixel_t;

endpackage

### design/scpb_group_core.sv
// Group state, coincidence test and per-group maximum tracking.
module scpb_group_core #(
	parameter int FRONT_STRIPS = 128,
	parameter int ENERGY_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [scpb_pkg::TIME_W-1:0]      hit_time,
	input  logic [scpb_pkg::STRIP_W-1:0]     hit_strip,
	input  logic [scpb_pkg::ENERGY_W-1:0]    hit_energy,
	input  scpb_pkg::win_cfg_t               win_cfg,
	output logic                             emit,
	output scpb_pkg::pixel_t                 pixel
);

	localparam int EW = (ENERGY_BITS < scpb_pkg::ENERGY_W) ? ENERGY_BITS : scpb_pkg::ENERGY_W;

	logic                          have_prev_q;
	logic [scpb_pkg::TIME_W-1:0]   prev_time_q;
	logic                          prev_front_q;
	logic [EW-1:0]                 front_energy_q;
	logic [scpb_pkg::PIX_W-1:0]    front_strip_q;
	logic [scpb_pkg::TIME_W-1:0]   front_time_q;
	logic [EW-1:0]                 back_energy_q;
	logic [scpb_pkg::STRIP_W-1:0]  back_strip_q;

	logic                          is_front;
	logic [EW-1:0]                 energy;
	logic [scpb_pkg::TIME_W-1:0]   diff_fwd;
	logic [scpb_pkg::TIME_W-1:0]   diff_bwd;
	logic [scpb_pkg::TIME_W-1:0]   gap;
	logic [scpb_pkg::WIN_W-1:0]    win;
	logic                          in_window;
	logic                          new_group;
	logic [EW-1:0]                 cur_front_e;
	logic [EW-1:0]                 cur_back_e;

	assign is_front = hit_strip < scpb_pkg::STRIP_W'(FRONT_STRIPS);
	assign energy   = hit_energy[EW-1:0];
	assign diff_fwd = hit_time - prev_time_q;
	assign diff_bwd = prev_time_q - hit_time;
	assign gap      = (hit_time >= prev_time_q) ? diff_fwd : diff_bwd;

	always_comb begin
		if (is_front) begin
			win = prev_front_q ? win_cfg.front_front : win_cfg.front_back;
		end else begin
			win = prev_front_q ? win_cfg.back_front : win_cfg.back_back;
		end
	end

	assign in_window = (gap[scpb_pkg::TIME_W-1:scpb_pkg::WIN_W] == '0) &&
	                   (gap[scpb_pkg::WIN_W-1:0] <= win);
	assign new_group = !have_prev_q || !in_window;
	assign emit      = have_prev_q && !in_window &&
	                   (front_energy_q != '0) && (back_energy_q != '0);

	// a new group compares against a cleared maximum
	assign cur_front_e = new_group ? '0 : front_energy_q;
	assign cur_back_e  = new_group ? '0 : back_energy_q;

	assign pixel.pixel_x      = front_strip_q;
	assign pixel.pixel_y      = back_strip_q[scpb_pkg::PIX_W-1:0];
	assign pixel.pixel_time   = front_time_q;
	assign pixel.energy_front = scpb_pkg::ENERGY_W'(front_energy_q);
	assign pixel.energy_back  = scpb_pkg::ENERGY_W'(back_energy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q    <= 1'b0;
			prev_time_q    <= '0;
			prev_front_q   <= 1'b0;
			front_energy_q <= '0;
			front_strip_q  <= '0;
			front_time_q   <= '0;
			back_energy_q  <= '0;
			back_strip_q   <= '0;
		end else if (step) begin
			have_prev_q  <= 1'b1;
			prev_time_q  <= hit_time;
			prev_front_q <= is_front;
			if (new_group) begin
				front_energy_q <= '0;
				front_strip_q  <= '0;
				front_time_q   <= '0;
				back_energy_q  <= '0;
				back_strip_q   <= '0;
			end
			if (is_front && (energy > cur_front_e)) begin
				front_energy_q <= energy;
				front_strip_q  <= hit_strip[scpb_pkg::PIX_W-1:0];
				front_time_q   <= hit_time;
			end
			if (!is_front && (energy > cur_back_e)) begin
				back_energy_q <= energy;
				back_strip_q  <= hit_strip;
			end
		end
	end

	a_emit_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> have_prev_q)
		else $error("pixel emitted with no open group");

	a_front_max_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !new_group) |=> (front_energy_q >= $past(front_energy_q)))
		else $error("front maximum dropped inside a group");

	a_back_max_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !new_group) |=> (back_energy_q >= $past(back_energy_q)))
		else $error("back maximum dropped inside a group");

endmodule

### design/strip_coincidence_pixel_builder_top.sv
// Strip coincidence pixel builder: stream ports, window registers, output register.
// Path: a taken hit waits in the input register until the group logic takes it; a pixel
// that it closes is loaded into the output register as the group logic updates.
// Throughput: one hit per cycle while the output side is ready; the combinational
// gap compare and registered maximum update of the group logic set this.
// Reset (arst_n low, asynchronous): no open group, windows at 2000 ns, both stages empty.
module strip_coincidence_pixel_builder_top #(
	parameter int FRONT_STRIPS = 128,
	parameter int ENERGY_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// hit_time[49:0], hit_strip[57:50], hit_energy[73:58], zero pad
	input  logic [scpb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pixel_x[6:0], pixel_y[13:7], pixel_time[63:14], energy_front[79:64],
	// energy_back[95:80]
	output logic [scpb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [scpb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scpb_pkg::WIN_W-1:0]          cfg_data
);

	scpb_pkg::win_cfg_t                  win_q;
	logic                                valid_s1;
	logic [scpb_pkg::TIME_W-1:0]         time_s1;
	logic [scpb_pkg::STRIP_W-1:0]        strip_s1;
	logic [scpb_pkg::ENERGY_W-1:0]       energy_s1;
	logic                                out_valid_q;
	scpb_pkg::pixel_t                    pixel_q;
	logic                                advance;
	logic                                emit;
	scpb_pkg::pixel_t                    pixel;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.front_front <= scpb_pkg::WIN_RESET;
			win_q.front_back  <= scpb_pkg::WIN_RESET;
			win_q.back_front  <= scpb_pkg::WIN_RESET;
			win_q.back_back   <= scpb_pkg::WIN_RESET;
		end else if (cfg_valid) begin
			case (scpb_pkg::cfg_idx_t'(cfg_index))
				scpb_pkg::CFG_WIN_FF: win_q.front_front <= cfg_data;
				scpb_pkg::CFG_WIN_FB: win_q.front_back  <= cfg_data;
				scpb_pkg::CFG_WIN_BF: win_q.back_front  <= cfg_data;
				scpb_pkg::CFG_WIN_BB: win_q.back_back   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			time_s1   <= s_axis_tdata[49:0];
			strip_s1  <= s_axis_tdata[57:50];
			energy_s1 <= s_axis_tdata[73:58];
		end
	end

	scpb_group_core #(
		.FRONT_STRIPS(FRONT_STRIPS),
		.ENERGY_BITS (ENERGY_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.hit_time  (time_s1),
		.hit_strip (strip_s1),
		.hit_energy(energy_s1),
		.win_cfg   (win_q),
		.emit      (emit),
		.pixel     (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			pixel_q <= pixel;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {pixel_q.energy_back, pixel_q.energy_front, pixel_q.pixel_time,
	                        pixel_q.pixel_y, pixel_q.pixel_x};

	a_pixel_energies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((pixel_q.energy_front != '0) && (pixel_q.energy_back != '0)))
		else $error("pixel with an empty front or back side");

	a_stall_holds_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |=> valid_s1)
		else $error("hit dropped while the output was stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input refused with an empty input register");

endmodule

### tb/strip_coincidence_pixel_builder_top_tb.sv
// Self-checking testbench for the pixel builder: directed hits, window writes, random traffic.
`timescale 1ns / 100ps

module strip_coincidence_pixel_builder_top_tb;

	localparam int FRONT_STRIPS = 128;
	localparam int BACK_OFFSET = 128;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam logic [scpb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd4;
	localparam logic [scpb_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam logic [scpb_pkg::WIN_W-1:0] WIN_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [scpb_pkg::IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [scpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [scpb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [scpb_pkg::WIN_W-1:0] cfg_data;

	strip_coincidence_pixel_builder_top #(
		.FRONT_STRIPS(FRONT_STRIPS),
		.ENERGY_BITS (scpb_pkg::ENERGY_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block: windows and open group
	logic [scpb_pkg::WIN_W-1:0] win_shadow [4];
	bit have_prev;
	logic [scpb_pkg::TIME_W-1:0] prev_time;
	bit prev_front;
	logic [scpb_pkg::ENERGY_W-1:0] grp_front_energy;
	logic [scpb_pkg::PIX_W-1:0] grp_front_strip;
	logic [scpb_pkg::TIME_W-1:0] grp_front_time;
	logic [scpb_pkg::ENERGY_W-1:0] grp_back_energy;
	logic [scpb_pkg::STRIP_W-1:0] grp_back_strip;

	scpb_pkg::pixel_t pending_pixels [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	logic [scpb_pkg::TIME_W-1:0] hit_clock = '0;
	int error_count = 0;
	int hits_sent = 0;
	int pixels_seen = 0;
	int reg_writes = 0;

	function automatic void group_reset();
		grp_front_energy = '0;
		grp_front_strip = '0;
		grp_front_time = '0;
		grp_back_energy = '0;
		grp_back_strip = '0;
	endfunction

	function automatic void group_merge(logic [scpb_pkg::TIME_W-1:0] t,
			logic [scpb_pkg::STRIP_W-1:0] strip,
			logic [scpb_pkg::ENERGY_W-1:0] energy, bit is_front);
		// strictly greater: ties keep the earlier hit, zero never counts
		if (is_front) begin
			if (energy > grp_front_energy) begin
				grp_front_energy = energy;
				grp_front_strip = strip[scpb_pkg::PIX_W-1:0];
				grp_front_time = t;
			end
		end else begin
			if (energy > grp_back_energy) begin
				grp_back_energy = energy;
				grp_back_strip = strip;
			end
		end
	endfunction

	function automatic logic [scpb_pkg::WIN_W-1:0] pair_window(bit is_front);
		if (is_front)
			return prev_front ? win_shadow[scpb_pkg::CFG_WIN_FF]
				: win_shadow[scpb_pkg::CFG_WIN_FB];
		return prev_front ? win_shadow[scpb_pkg::CFG_WIN_BF]
			: win_shadow[scpb_pkg::CFG_WIN_BB];
	endfunction

	function automatic void expect_pixel(scpb_pkg::pixel_t px);
		pending_pixels = {pending_pixels, px};
	endfunction

	function automatic void predict_pixel(logic [scpb_pkg::TIME_W-1:0] t,
			logic [scpb_pkg::STRIP_W-1:0] strip, logic [scpb_pkg::ENERGY_W-1:0] energy);
		bit is_front;
		logic [scpb_pkg::TIME_W-1:0] gap;
		logic [scpb_pkg::STRIP_W-1:0] y_full;
		scpb_pkg::pixel_t px;
		is_front = (strip < FRONT_STRIPS);
		if (!have_prev) begin
			group_reset();
			group_merge(t, strip, energy, is_front);
		end else begin
			gap = (t >= prev_time) ? (t - prev_time) : (prev_time - t);
			if (gap <= scpb_pkg::TIME_W'(pair_window(is_front))) begin
				group_merge(t, strip, energy, is_front);
			end else begin
				if (grp_front_energy != 0 && grp_back_energy != 0) begin
					y_full = grp_back_strip - scpb_pkg::STRIP_W'(BACK_OFFSET);
					px.pixel_x = grp_front_strip;
					px.pixel_y = y_full[scpb_pkg::PIX_W-1:0];
					px.pixel_time = grp_front_time;
					px.energy_front = grp_front_energy;
					px.energy_back = grp_back_energy;
					expect_pixel(px);
				end
				group_reset();
				group_merge(t, strip, energy, is_front);
			end
		end
		have_prev = 1'b1;
		prev_time = t;
		prev_front = is_front;
	endfunction

	function automatic void check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, exp_v, act_v);
			error_count++;
		end
	endfunction

	function automatic void check_pixel(logic [scpb_pkg::OUT_TDATA_W-1:0] d);
		scpb_pkg::pixel_t px;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel, expected none actual %h", $time, d);
			error_count++;
			return;
		end
		px = pending_pixels.pop_front();
		pixels_seen++;
		check_field("pixel_x", 64'(px.pixel_x), 64'(d[6:0]));
		check_field("pixel_y", 64'(px.pixel_y), 64'(d[13:7]));
		check_field("pixel_time", 64'(px.pixel_time), 64'(d[63:14]));
		check_field("energy_front", 64'(px.energy_front), 64'(d[79:64]));
		check_field("energy_back", 64'(px.energy_back), 64'(d[95:80]));
	endfunction

	// output side: random stall and result check
	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			if (m_axis_tvalid && m_axis_tready)
				check_pixel(m_axis_tdata);
		end
	end

	task automatic send_hit(logic [scpb_pkg::TIME_W-1:0] t,
			logic [scpb_pkg::STRIP_W-1:0] strip, logic [scpb_pkg::ENERGY_W-1:0] energy);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, energy, strip, t};
		do @(posedge clk); while (!s_axis_tready);
		hits_sent++;
		hit_clock = t;
		predict_pixel(t, strip, energy);
	endtask

	// Random hit biased around the window of the pair it forms with the previous hit
	task automatic send_random_hit();
		bit is_front;
		logic [scpb_pkg::STRIP_W-1:0] strip;
		logic [scpb_pkg::ENERGY_W-1:0] energy;
		logic [scpb_pkg::TIME_W-1:0] win;
		logic [scpb_pkg::TIME_W-1:0] t;
		int unsigned pick;
		is_front = 1'($urandom_range(0, 1));
		strip = is_front ? scpb_pkg::STRIP_W'($urandom_range(0, FRONT_STRIPS - 1))
			: scpb_pkg::STRIP_W'($urandom_range(FRONT_STRIPS, 255));
		pick = $urandom_range(0, 9);
		energy = (pick == 0) ? '0 : (pick == 1) ? '1 : scpb_pkg::ENERGY_W'($urandom);
		win = scpb_pkg::TIME_W'(pair_window(is_front));
		t = hit_clock;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			t = t + $urandom_range(0, 32'(win));
		else if (pick < 55)
			t = t + win;
		else if (pick < 62)
			t = t + win + 1;
		else if (pick < 85)
			t = t + win + 1 + $urandom_range(0, 5000);
		else if (pick < 93)
			t = t;
		else if (pick < 97)
			t = t - $urandom_range(0, 32'(win) + 1);
		else
			t = scpb_pkg::TIME_W'({$urandom, $urandom});
		send_hit(t, strip, energy);
	endtask

	task automatic send_random_burst(int count);
		repeat (count) send_random_hit();
	endtask

	// Stop sending and wait until every pixel is out and the pipeline has emptied
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [scpb_pkg::CFG_IDX_W-1:0] idx,
			logic [scpb_pkg::WIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		if (idx <= scpb_pkg::CFG_WIN_BB)
			win_shadow[idx] = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_windows(logic [scpb_pkg::WIN_W-1:0] ff,
			logic [scpb_pkg::WIN_W-1:0] fb, logic [scpb_pkg::WIN_W-1:0] bf,
			logic [scpb_pkg::WIN_W-1:0] bb);
		settle_block();
		write_window(scpb_pkg::CFG_WIN_FF, ff);
		write_window(scpb_pkg::CFG_WIN_FB, fb);
		write_window(scpb_pkg::CFG_WIN_BF, bf);
		write_window(scpb_pkg::CFG_WIN_BB, bb);
	endtask

	// Reset windows; first hit, ties, zero energies, gap on the window edge, time reversal
	task automatic test_reset_defaults();
		send_hit(50'd0, 8'd0, 16'hFFFF);
		send_hit(50'd2000, 8'd255, 16'd1);
		send_hit(50'd2000, 8'd127, 16'hFFFF);
		send_hit(50'd2000, 8'd128, 16'd0);
		send_hit(50'd4001, 8'd64, 16'd7);
		send_hit(50'd4001, 8'd130, 16'd0);
		send_hit(50'd10000, 8'd10, 16'd3);
		send_hit(50'd8600, 8'd200, 16'd9);
		send_hit(50'd8600, 8'd201, 16'd9);
		send_hit(TIME_MAX, 8'd1, 16'd2);
		send_hit(TIME_MAX, 8'd129, 16'hFFFF);
		send_hit(TIME_MAX - 50'd2000, 8'd126, 16'h8000);
		send_hit(50'd0, 8'd128, 16'd5);
		send_hit(50'd1, 8'd130, 16'd6);
		send_hit(50'd5000, 8'd127, 16'd0);
		send_hit(50'd5000, 8'd0, 16'd0);
		send_hit(50'd9000, 8'd255, 16'd1);
		send_hit(50'd9000, 8'd77, 16'h5555);
		send_hit(50'd20000, 8'd66, 16'hAAAA);
	endtask

	// Extreme and distinct window settings, writes to unused indexes
	task automatic test_window_registers();
		int i;
		write_all_windows('0, '0, '0, '0);
		send_hit(hit_clock + 50'd100, 8'd3, 16'd5);
		send_hit(hit_clock, 8'd200, 16'd5);
		send_hit(hit_clock + 50'd1, 8'd4, 16'd6);
		send_random_burst(20);
		write_all_windows(WIN_MAX, WIN_MAX, WIN_MAX, WIN_MAX);
		send_hit(hit_clock + 50'd5000000, 8'd8, 16'd9);
		send_hit(hit_clock + scpb_pkg::TIME_W'(WIN_MAX), 8'd150, 16'd9);
		send_hit(hit_clock + scpb_pkg::TIME_W'(WIN_MAX) + 50'd1, 8'd9, 16'd9);
		send_random_burst(20);
		write_all_windows(20'd10, 20'd300, 20'd5000, 20'd70000);
		for (i = CFG_IDX_SPARE; i < (1 << scpb_pkg::CFG_IDX_W); i++)
			write_window(scpb_pkg::CFG_IDX_W'(i), scpb_pkg::WIN_W'($urandom));
		send_random_burst(30);
	endtask

	task automatic test_random_traffic();
		write_all_windows(scpb_pkg::WIN_W'($urandom_range(0, 5000)),
			scpb_pkg::WIN_W'($urandom_range(0, 5000)),
			scpb_pkg::WIN_W'($urandom_range(0, 5000)),
			scpb_pkg::WIN_W'($urandom_range(0, 5000)));
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_random_burst(170);

		write_all_windows('0, '0, '0, '0);
		tx_idle_pct = 86;
		rx_stall_pct = 0;
		send_random_burst(80);
		settle_block();
		send_random_burst(80);

		write_all_windows(WIN_MAX, WIN_MAX, WIN_MAX, WIN_MAX);
		tx_idle_pct = 0;
		rx_stall_pct = 86;
		send_random_burst(170);

		write_all_windows(scpb_pkg::WIN_W'($urandom), scpb_pkg::WIN_W'($urandom),
			scpb_pkg::WIN_W'($urandom), scpb_pkg::WIN_W'($urandom));
		tx_idle_pct = 8;
		rx_stall_pct = 8;
		send_random_burst(170);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_random_burst(20);
	endtask

	initial begin
		int waited;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b1;
		cfg_valid <= 1'b0;
		cfg_index <= scpb_pkg::CFG_WIN_FF;
		cfg_data <= '0;
		foreach (win_shadow[i]) win_shadow[i] = scpb_pkg::WIN_RESET;
		have_prev = 1'b0;
		prev_time = '0;
		prev_front = 1'b0;
		group_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_window_registers();
		test_random_traffic();

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			$display("%0t: %0d pixels never arrived, expected %h actual none", $time,
				pending_pixels.size(), pending_pixels[0]);
			error_count += pending_pixels.size();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d hits, %0d pixels checked, %0d window register writes.",
			hits_sent, pixels_seen, reg_writes);
		$display("Windows at zero, max and random; idle and stall phases on both sides.");
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("Regression FAIL");
		$finish;
	end

endmodule
